FILE: rtl/erp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erp_pkg
// Shared types and constants of the encoder rate pushback reporter.
// ----------------------------------------------------------------------------
package erp_pkg;

	localparam int unsigned CMD_DEPTH_DEF = 2;
	localparam int unsigned RES_DEPTH_DEF = 2;

	localparam logic [16:0] Q16_ONE         = 17'd65536;
	localparam logic [19:0] PUSHBACK_START  = 20'd50;
	localparam logic [19:0] QUEUE_SCALE_MS  = 20'd1000;
	localparam logic [31:0] MIN_REPORT_BPS  = 32'd50000;
	localparam logic [7:0]  LOSS_MAX        = 8'd255;
	localparam logic [19:0] MAX_QUEUE_RESET = 20'd2000;

	// floor(q * 65536 / 1000) == (q * RECIP_1000) >> RECIP_SHIFT for q < 1000
	localparam logic [26:0] RECIP_1000  = 27'd68719477;
	localparam int unsigned RECIP_SHIFT = 20;

	typedef enum logic [1:0] {
		OP_AVAIL  = 2'd0,
		OP_TARGET = 2'd1,
		OP_QUEUE  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic {
		REG_PUSHBACK_MODE = 1'b0,
		REG_MAX_QUEUE_MS  = 1'b1
	} reg_idx_t;

	// Snapshot of the stored event state after one transaction
	typedef struct packed {
		logic [31:0] target_bps;
		logic [16:0] loss_q16;
		logic [19:0] rtt_ms;
		logic [19:0] period_ms;
		logic        net_up;
		logic [19:0] queue_ms;
	} cmd_t;

	typedef struct packed {
		logic [31:0] bps;
		logic [7:0]  loss;
		logic [19:0] rtt_ms;
		logic [19:0] period_ms;
	} res_t;

endpackage

FILE: rtl/erp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erp_fifo
// Small register queue; used between front and back and for results.
// ----------------------------------------------------------------------------
module erp_fifo #(
	parameter int unsigned DEPTH = erp_pkg::CMD_DEPTH_DEF,
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic             full
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/erp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erp_front
// Accepts events, keeps the latest value of each kind and queues a snapshot
// for every event that needs a recompute.
// ----------------------------------------------------------------------------
module erp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [1:0]    opcode,
	input  logic          network_up,
	input  logic [31:0]   target_bps,
	input  logic [16:0]   loss_ratio_q16,
	input  logic [19:0]   rtt_in_ms,
	input  logic [19:0]   probe_period_ms,
	input  logic [19:0]   queue_ms,
	output logic          cmd_push,
	output erp_pkg::cmd_t cmd_data
);

	logic          have_target_q;
	erp_pkg::cmd_t state_q;
	erp_pkg::cmd_t state_nx;
	logic          have_target_nx;
	logic          known_op;

	always_comb begin
		state_nx       = state_q;
		have_target_nx = have_target_q;
		known_op       = 1'b1;
		unique case (erp_pkg::op_t'(opcode))
			erp_pkg::OP_AVAIL: begin
				state_nx.net_up = network_up;
			end
			erp_pkg::OP_TARGET: begin
				have_target_nx     = 1'b1;
				state_nx.target_bps = target_bps;
				state_nx.loss_q16   = loss_ratio_q16;
				state_nx.rtt_ms     = rtt_in_ms;
				state_nx.period_ms  = probe_period_ms;
			end
			erp_pkg::OP_QUEUE: begin
				state_nx.queue_ms = queue_ms;
			end
			erp_pkg::OP_NONE: begin
				known_op = 1'b0;
			end
		endcase
	end

	// Drop unknown events and anything before the first target
	assign cmd_push = accept && known_op && have_target_nx;
	assign cmd_data = state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_target_q <= 1'b0;
			state_q       <= '{target_bps: '0, loss_q16: '0, rtt_ms: '0,
			                   period_ms: '0, net_up: 1'b1, queue_ms: '0};
		end else if (accept && known_op) begin
			have_target_q <= have_target_nx;
			state_q       <= state_nx;
		end
	end

endmodule

FILE: rtl/erp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erp_back
// Runs one snapshot at a time: factor update, bitrate scaling, change check.
// ----------------------------------------------------------------------------
module erp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pushback_mode,
	input  logic [19:0]   max_queue_ms,
	input  logic          cmd_empty,
	input  erp_pkg::cmd_t cmd_data,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output erp_pkg::res_t res_data
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_FACTOR = 4'b0010,
		ST_SCALE  = 4'b0100,
		ST_REPORT = 4'b1000
	} st_t;

	st_t           state_q;
	erp_pkg::cmd_t entry_s1;
	logic [36:0]   quot_s1;
	logic [7:0]    loss_s1;
	logic [16:0]   factor_s2;
	logic [48:0]   scaled_s3;
	logic [16:0]   factor_q;
	logic [31:0]   last_bps_q;
	logic [7:0]    last_loss_q;
	logic [19:0]   last_rtt_q;

	logic [24:0]   loss_prod;
	logic [8:0]    loss_full;
	logic [16:0]   cand;
	logic [16:0]   factor_new;
	logic          apply_factor;
	logic [31:0]   bps;
	logic          changed;

	assign cmd_pop = (state_q == ST_IDLE) && !cmd_empty && !res_full;

	// loss * 255 = (loss << 8) - loss
	assign loss_prod = {cmd_data.loss_q16, 8'd0} - {8'd0, cmd_data.loss_q16};
	assign loss_full = loss_prod[24:16];

	always_comb begin
		cand = '0;
		if (entry_s1.queue_ms < erp_pkg::QUEUE_SCALE_MS) begin
			cand = erp_pkg::Q16_ONE - quot_s1[erp_pkg::RECIP_SHIFT +: 17];
		end
		factor_new = factor_q;
		if (entry_s1.queue_ms == '0) begin
			factor_new = erp_pkg::Q16_ONE;
		end else if (entry_s1.queue_ms > erp_pkg::PUSHBACK_START) begin
			if (cand < factor_q) begin
				factor_new = cand;
			end
		end
	end

	assign apply_factor = entry_s1.net_up && pushback_mode;

	always_comb begin
		bps = entry_s1.target_bps;
		if (!entry_s1.net_up) begin
			bps = '0;
		end else if (!pushback_mode) begin
			if (entry_s1.queue_ms > max_queue_ms) begin
				bps = '0;
			end
		end else begin
			bps = scaled_s3[47:16];
			if (bps < erp_pkg::MIN_REPORT_BPS) begin
				bps = '0;
			end
		end
	end

	assign changed = (last_bps_q != bps) ||
	                 ((bps != '0) && ((last_loss_q != loss_s1) ||
	                                  (last_rtt_q != entry_s1.rtt_ms)));

	assign res_push = (state_q == ST_REPORT) && changed;
	assign res_data = '{bps: bps, loss: loss_s1, rtt_ms: entry_s1.rtt_ms,
	                    period_ms: entry_s1.period_ms};

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			entry_s1 <= cmd_data;
			quot_s1  <= 37'(cmd_data.queue_ms[9:0] * erp_pkg::RECIP_1000);
			loss_s1  <= loss_full[8] ? erp_pkg::LOSS_MAX : loss_full[7:0];
		end
		if (state_q == ST_FACTOR) begin
			factor_s2 <= apply_factor ? factor_new : factor_q;
		end
		if (state_q == ST_SCALE) begin
			scaled_s3 <= 49'(entry_s1.target_bps * factor_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			factor_q    <= erp_pkg::Q16_ONE;
			last_bps_q  <= '0;
			last_loss_q <= '0;
			last_rtt_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						state_q <= ST_FACTOR;
					end
				end
				ST_FACTOR: begin
					if (apply_factor) begin
						factor_q <= factor_new;
					end
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_REPORT;
				end
				ST_REPORT: begin
					// Keep the last values even when nothing is reported
					last_bps_q  <= bps;
					last_loss_q <= loss_s1;
					last_rtt_q  <= entry_s1.rtt_ms;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/encoder_rate_pushback_reporter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_rate_pushback_reporter
// Tracks network, target-rate and queue events and reports the encoder
// bitrate whenever it, or loss or round trip under a live bitrate, changes.
// ----------------------------------------------------------------------------
//  channel   signals                                      direction
//  event     push, full, opcode .. queue_ms               in
//  report    empty, pop, report_bps .. report_period_ms   out
//  config    wr_en, wr_index, wr_data                     in
//
//  An event is accepted into the command queue and waits there; the back
//  end works on one queued event at a time (factor, multiply, compare) and
//  pops the next only from idle, with space free in the result queue.
//  Reset clears all stored events; the first report comes after a target.
//  Either side may stall: full rises when the command queue is full, and
//  the back end waits while the result queue is full.
// ----------------------------------------------------------------------------
module encoder_rate_pushback_reporter #(
	parameter int unsigned CMD_DEPTH = erp_pkg::CMD_DEPTH_DEF,
	parameter int unsigned RES_DEPTH = erp_pkg::RES_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [19:0] wr_data,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  opcode,
	input  logic        network_up,
	input  logic [31:0] target_bps,
	input  logic [16:0] loss_ratio_q16,
	input  logic [19:0] rtt_in_ms,
	input  logic [19:0] probe_period_ms,
	input  logic [19:0] queue_ms,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] report_bps,
	output logic [7:0]  report_loss,
	output logic [19:0] report_rtt_ms,
	output logic [19:0] report_period_ms
);

	logic          pushback_mode_q;
	logic [19:0]   max_queue_ms_q;
	logic          accept;
	logic          cmd_push;
	logic          cmd_pop;
	logic          cmd_empty;
	logic          cmd_full;
	erp_pkg::cmd_t cmd_wdata;
	erp_pkg::cmd_t cmd_rdata;
	logic          res_push;
	logic          res_full;
	erp_pkg::res_t res_wdata;
	erp_pkg::res_t res_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pushback_mode_q <= 1'b0;
			max_queue_ms_q  <= erp_pkg::MAX_QUEUE_RESET;
		end else if (wr_en) begin
			unique case (erp_pkg::reg_idx_t'(wr_index))
				erp_pkg::REG_PUSHBACK_MODE: pushback_mode_q <= wr_data[0];
				erp_pkg::REG_MAX_QUEUE_MS:  max_queue_ms_q  <= wr_data;
			endcase
		end
	end

	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	erp_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.opcode          (opcode),
		.network_up      (network_up),
		.target_bps      (target_bps),
		.loss_ratio_q16  (loss_ratio_q16),
		.rtt_in_ms       (rtt_in_ms),
		.probe_period_ms (probe_period_ms),
		.queue_ms        (queue_ms),
		.cmd_push        (cmd_push),
		.cmd_data        (cmd_wdata)
	);

	erp_fifo #(
		.DEPTH (CMD_DEPTH),
		.WIDTH ($bits(erp_pkg::cmd_t))
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.wdata  (cmd_wdata),
		.rd     (cmd_pop),
		.rdata  (cmd_rdata),
		.empty  (cmd_empty),
		.full   (cmd_full)
	);

	erp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pushback_mode (pushback_mode_q),
		.max_queue_ms  (max_queue_ms_q),
		.cmd_empty     (cmd_empty),
		.cmd_data      (cmd_rdata),
		.cmd_pop       (cmd_pop),
		.res_full      (res_full),
		.res_push      (res_push),
		.res_data      (res_wdata)
	);

	erp_fifo #(
		.DEPTH (RES_DEPTH),
		.WIDTH ($bits(erp_pkg::res_t))
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_push),
		.wdata  (res_wdata),
		.rd     (pop),
		.rdata  (res_rdata),
		.empty  (empty),
		.full   (res_full)
	);

	assign report_bps       = res_rdata.bps;
	assign report_loss      = res_rdata.loss;
	assign report_rtt_ms    = res_rdata.rtt_ms;
	assign report_period_ms = res_rdata.period_ms;

	a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command pushed into full queue");

	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");

	a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty && !res_full)
		else $error("back end started without command or result space");

	a_report_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> $past(cmd_pop, 3))
		else $error("result not three cycles after command pop");

endmodule
